@@ rtl/ckhl_pkg.sv @@
// shared types, constants and word-list lookup for the c keyword highlight lexer
// no dependencies; imported by ckhl_dp, ckhl_ctrl, the top level and the testbench

package ckhl_pkg;

    localparam int WORD_HOLD_DEPTH = 8;
    localparam int WIDX_W          = $clog2(WORD_HOLD_DEPTH);
    localparam int WCNT_W          = $clog2(WORD_HOLD_DEPTH + 1);
    localparam int NUM_KEYWORDS    = 9;
    localparam int NUM_TYPES       = 6;
    localparam int LIST_WORD_MAX   = 8;

    // style bytes
    localparam logic [7:0] STYLE_DEFAULT   = 8'h41;
    localparam logic [7:0] STYLE_COMMENT   = 8'h42;
    localparam logic [7:0] STYLE_STRING    = 8'h44;
    localparam logic [7:0] STYLE_DIRECTIVE = 8'h45;
    localparam logic [7:0] STYLE_TYPE      = 8'h46;
    localparam logic [7:0] STYLE_KEYWORD   = 8'h47;
    localparam logic [7:0] STYLE_NONE      = 8'h00;

    // characters with a meaning of their own
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_COMMENT   = 2'd1,
        MODE_STRING    = 2'd2,
        MODE_DIRECTIVE = 2'd3
    } t_lex_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_PRE,
        ST_FLUSH,
        ST_MAIN,
        ST_TAIL
    } t_state;

    typedef enum logic [1:0] {
        SRC_PRE,
        SRC_FLUSH,
        SRC_MAIN,
        SRC_TAIL
    } t_emit_src;

    typedef struct packed {
        logic      accept;
        logic      emit;
        t_emit_src src;
        logic      last;
        logic      flush_step;
    } t_dp_cmd;

    typedef struct packed {
        logic pre_en;
        logic flush_en;
        logic flush_last;
        logic main_en;
        logic tail_en;
        logic fin;
    } t_dp_status;

    typedef logic [WORD_HOLD_DEPTH-1:0][7:0] t_word_buf;

    typedef struct packed {
        logic [3:0]                 len;
        logic [8*LIST_WORD_MAX-1:0] txt;   // first character in the highest used byte
    } t_word_ent;

    localparam t_word_ent KEYWORDS [NUM_KEYWORDS] = '{
        '{4'd2, "if"}, '{4'd4, "else"}, '{4'd5, "while"}, '{4'd6, "return"},
        '{4'd3, "for"}, '{4'd6, "switch"}, '{4'd4, "case"}, '{4'd5, "break"},
        '{4'd8, "continue"}
    };

    localparam t_word_ent TYPES [NUM_TYPES] = '{
        '{4'd3, "int"}, '{4'd4, "char"}, '{4'd4, "void"}, '{4'd5, "float"},
        '{4'd6, "double"}, '{4'd4, "bool"}
    };

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    function automatic logic word_hit(input t_word_ent ent, input t_word_buf chars,
                                      input logic [WCNT_W-1:0] len);
        logic hit;
        int   pos;
        hit = (len == WCNT_W'(ent.len));
        for (int i = 0; i < LIST_WORD_MAX; i++) begin
            pos = int'(ent.len) - 1 - i;
            if (pos < 0) begin
                pos = 0;
            end
            if ((i < int'(ent.len)) && (chars[i] != 8'(ent.txt >> (8 * pos)))) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // keyword style, type style, or STYLE_NONE when the word is in neither list
    function automatic logic [7:0] match_word(input t_word_buf chars,
                                              input logic [WCNT_W-1:0] len);
        logic kw;
        logic ty;
        kw = 1'b0;
        ty = 1'b0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw = kw | word_hit(KEYWORDS[k], chars, len);
        end
        for (int k = 0; k < NUM_TYPES; k++) begin
            ty = ty | word_hit(TYPES[k], chars, len);
        end
        return kw ? STYLE_KEYWORD : (ty ? STYLE_TYPE : STYLE_NONE);
    endfunction

endpackage

@@ rtl/ckhl_dp.sv @@
// datapath: lexer state, word hold, per-character emit plan and output register
// depends on ckhl_pkg; driven by ckhl_ctrl through t_dp_cmd

module ckhl_dp
    import ckhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_text_char,
    input  logic [7:0]  i_prior_style,
    input  logic        i_end_of_text,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic [7:0]  o_char_style,
    output logic        o_last_style
);

    t_lex_mode           r_mode, n_mode;
    logic                r_at_start, n_at_start;
    logic                r_slash, n_slash;
    logic                r_long, n_long;
    logic [WCNT_W-1:0]   r_wcount, n_wcount;
    t_word_buf           r_wchars;
    t_word_buf           r_wpriors;

    logic                r_pre_en, n_pre_en;
    logic [7:0]          r_pre_style, n_pre_style;
    logic [WCNT_W-1:0]   r_flush_len, n_flush_len;
    logic                r_flush_raw, n_flush_raw;
    logic                r_main_en, n_main_en;
    logic [7:0]          r_main_style, n_main_style;
    logic                r_tail_en, n_tail_en;
    logic                r_fin;
    logic [WIDX_W-1:0]   r_flush_idx;

    logic [7:0]          r_out_style;
    logic                r_out_last;

    logic                store_en;
    logic [WIDX_W-1:0]   store_idx;
    logic                do_plain;
    logic [7:0]          match_style;
    logic [7:0]          flush_style;
    logic [7:0]          emit_style;

    // next lexer state and emit plan for the incoming character
    always_comb begin
        n_mode       = r_mode;
        n_at_start   = 1'b0;
        n_slash      = r_slash;
        n_long       = r_long;
        n_wcount     = r_wcount;
        n_pre_en     = 1'b0;
        n_pre_style  = STYLE_DEFAULT;
        n_flush_len  = '0;
        n_flush_raw  = 1'b0;
        n_main_en    = 1'b0;
        n_main_style = STYLE_DEFAULT;
        n_tail_en    = 1'b0;
        store_en     = 1'b0;
        store_idx    = '0;
        do_plain     = 1'b0;

        case (r_mode)
            MODE_COMMENT, MODE_DIRECTIVE: begin
                n_main_en = 1'b1;
                if (i_text_char == CH_NEWLINE) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    n_main_style = (r_mode == MODE_COMMENT) ? STYLE_COMMENT
                                                            : STYLE_DIRECTIVE;
                end
            end
            MODE_STRING: begin
                n_main_en    = 1'b1;
                n_main_style = STYLE_STRING;
                if (i_text_char == CH_QUOTE) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: begin
                if (r_slash) begin
                    n_slash  = 1'b0;
                    n_pre_en = 1'b1;
                    if (i_text_char == CH_SLASH) begin
                        n_pre_style  = STYLE_COMMENT;
                        n_main_en    = 1'b1;
                        n_main_style = STYLE_COMMENT;
                        n_mode       = MODE_COMMENT;
                    end else begin
                        do_plain = 1'b1;
                    end
                end else if (r_long) begin
                    if (is_alnum(i_text_char)) begin
                        n_main_en    = 1'b1;
                        n_main_style = i_prior_style;
                    end else begin
                        n_long   = 1'b0;
                        do_plain = 1'b1;
                    end
                end else if (r_wcount != '0) begin
                    if (is_alnum(i_text_char)) begin
                        if (r_wcount < WCNT_W'(WORD_HOLD_DEPTH)) begin
                            store_en  = 1'b1;
                            store_idx = r_wcount[WIDX_W-1:0];
                            n_wcount  = r_wcount + 1'b1;
                        end else begin
                            // word outgrew the hold: release it unstyled
                            n_flush_len  = WCNT_W'(WORD_HOLD_DEPTH);
                            n_flush_raw  = 1'b1;
                            n_main_en    = 1'b1;
                            n_main_style = i_prior_style;
                            n_wcount     = '0;
                            n_long       = 1'b1;
                        end
                    end else begin
                        n_flush_len = r_wcount;
                        n_wcount    = '0;
                        do_plain    = 1'b1;
                    end
                end else begin
                    do_plain = 1'b1;
                end
            end
        endcase

        if (do_plain) begin
            if (i_text_char == CH_SLASH) begin
                n_slash = 1'b1;
            end else if (i_text_char == CH_QUOTE) begin
                n_main_en    = 1'b1;
                n_main_style = STYLE_STRING;
                n_mode       = MODE_STRING;
            end else if (r_at_start && (i_text_char == CH_HASH)) begin
                n_main_en    = 1'b1;
                n_main_style = STYLE_DIRECTIVE;
                n_mode       = MODE_DIRECTIVE;
            end else if (is_letter(i_text_char)) begin
                store_en  = 1'b1;
                store_idx = '0;
                n_wcount  = WCNT_W'(1);
            end else begin
                n_main_en    = 1'b1;
                n_main_style = STYLE_DEFAULT;
            end
        end

        // end of text: release whatever is held and return to the reset state
        if (i_end_of_text) begin
            if (n_wcount != '0) begin
                n_flush_len = n_wcount;
            end
            n_tail_en  = n_slash;
            n_mode     = MODE_NORMAL;
            n_at_start = 1'b1;
            n_slash    = 1'b0;
            n_wcount   = '0;
            n_long     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_at_start  <= 1'b1;
            r_slash     <= 1'b0;
            r_long      <= 1'b0;
            r_wcount    <= '0;
            r_pre_en    <= 1'b0;
            r_flush_len <= '0;
            r_flush_raw <= 1'b0;
            r_main_en   <= 1'b0;
            r_tail_en   <= 1'b0;
            r_fin       <= 1'b0;
            r_flush_idx <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_mode      <= n_mode;
                r_at_start  <= n_at_start;
                r_slash     <= n_slash;
                r_long      <= n_long;
                r_wcount    <= n_wcount;
                r_pre_en    <= n_pre_en;
                r_flush_len <= n_flush_len;
                r_flush_raw <= n_flush_raw;
                r_main_en   <= n_main_en;
                r_tail_en   <= n_tail_en;
                r_fin       <= i_end_of_text;
                r_flush_idx <= '0;
            end else if (i_cmd.flush_step) begin
                r_flush_idx <= r_flush_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pre_style  <= n_pre_style;
            r_main_style <= n_main_style;
            if (store_en) begin
                r_wchars[store_idx]  <= i_text_char;
                r_wpriors[store_idx] <= i_prior_style;
            end
        end
        if (i_cmd.emit) begin
            r_out_style <= emit_style;
            r_out_last  <= i_cmd.last;
        end
    end

    assign match_style = match_word(r_wchars, r_flush_len);
    assign flush_style = (!r_flush_raw && (match_style != STYLE_NONE)) ? match_style
                                                                        : r_wpriors[r_flush_idx];

    always_comb begin
        case (i_cmd.src)
            SRC_PRE:   emit_style = r_pre_style;
            SRC_FLUSH: emit_style = flush_style;
            SRC_MAIN:  emit_style = r_main_style;
            SRC_TAIL:  emit_style = STYLE_DEFAULT;
            default:   emit_style = STYLE_DEFAULT;
        endcase
    end

    assign o_status.pre_en     = r_pre_en;
    assign o_status.flush_en   = (r_flush_len != '0);
    assign o_status.flush_last = ((WCNT_W'(r_flush_idx) + 1'b1) == r_flush_len);
    assign o_status.main_en    = r_main_en;
    assign o_status.tail_en    = r_tail_en;
    assign o_status.fin        = r_fin;

    assign o_char_style = r_out_style;
    assign o_last_style = r_out_last;

endmodule

@@ rtl/ckhl_ctrl.sv @@
// controller: sequences the emit phases of one character and owns both handshakes
// depends on ckhl_pkg; commands ckhl_dp through t_dp_cmd

module ckhl_ctrl
    import ckhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_state after_main, after_flush, after_pre, from_plan;

    assign out_free = !r_out_valid || i_out_ready;

    // first phase still to run after each phase
    always_comb begin
        after_main  = i_status.tail_en  ? ST_TAIL  : ST_IDLE;
        after_flush = i_status.main_en  ? ST_MAIN  : after_main;
        after_pre   = i_status.flush_en ? ST_FLUSH : after_flush;
        from_plan   = i_status.pre_en   ? ST_PRE   : after_pre;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: n_state = from_plan;
            ST_PRE: begin
                if (out_free) begin
                    n_state = after_pre;
                end
            end
            ST_FLUSH: begin
                if (out_free && i_status.flush_last) begin
                    n_state = after_flush;
                end
            end
            ST_MAIN: begin
                if (out_free) begin
                    n_state = after_main;
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = SRC_PRE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_PRE: begin
                o_cmd.emit = out_free;
                o_cmd.src  = SRC_PRE;
                o_cmd.last = i_status.fin && (after_pre == ST_IDLE);
            end
            ST_FLUSH: begin
                o_cmd.emit       = out_free;
                o_cmd.src        = SRC_FLUSH;
                o_cmd.flush_step = out_free;
                o_cmd.last       = i_status.fin && i_status.flush_last
                                   && (after_flush == ST_IDLE);
            end
            ST_MAIN: begin
                o_cmd.emit = out_free;
                o_cmd.src  = SRC_MAIN;
                o_cmd.last = i_status.fin && (after_main == ST_IDLE);
            end
            ST_TAIL: begin
                o_cmd.emit = out_free;
                o_cmd.src  = SRC_TAIL;
                o_cmd.last = i_status.fin;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/c_keyword_highlight_lexer_unit.sv @@
// C syntax highlighting lexer: one text character in, one style byte out per character.
// A character is accepted and planned in the following cycle; the style bytes it then
// releases pass one at a time through the single output register. A character releases
// 0 to 9 style bytes: usually 1, 0 while a word or a '/' is held, up to 9 when a held
// word ends (the word plus the character that ends it) or outgrows the 8-character
// hold. Output stalls can hold back any of them.
// The next character is taken while the last style byte still waits in the output
// register. Style bytes:
// 'A' default, 'B' comment, 'D' string, 'E' directive, 'F' type, 'G' keyword; words
// that match neither list keep their stored style. tlast on the input ends the text,
// flushes anything held, is repeated on the final style byte and clears all state.
// depends on ckhl_pkg, ckhl_ctrl and ckhl_dp

module c_keyword_highlight_lexer_unit
    import ckhl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] text_char, [15:8] prior_style
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_style
    output logic        o_m_axis_tlast    // last_style
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ckhl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ckhl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_char   (i_s_axis_tdata[7:0]),
        .i_prior_style (i_s_axis_tdata[15:8]),
        .i_end_of_text (i_s_axis_tlast),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_char_style  (o_m_axis_tdata),
        .o_last_style  (o_m_axis_tlast)
    );

endmodule

@@ rtl/ckhl_chk.sv @@
// port-level checks for c_keyword_highlight_lexer_unit, bound to every instance
// depends only on the top level's ports

module ckhl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

    // one character at a time: busy straight after taking a beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while previous character still in work");

    // a new style byte only comes from a character in work
    a_emit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("style byte emitted while idle");

    // out of reset: idle, nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not idle after reset");

endmodule

bind c_keyword_highlight_lexer_unit ckhl_chk u_ckhl_chk (.*);

@@ dv/c_keyword_highlight_lexer_unit_tb.sv @@
// self-checking testbench for c_keyword_highlight_lexer_unit: drives text beats, predicts
// the style beats in a scoreboard class and compares them on the output stream
// depends on ckhl_pkg and c_keyword_highlight_lexer_unit
`timescale 1ns / 1ps

module c_keyword_highlight_lexer_unit_tb;
    import ckhl_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_CHARS  = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int RX_HOLD       = 150;

    // style predictor and queue of style beats still to come
    class style_scoreboard;
        typedef struct packed {
            logic [7:0] style;
            logic       last;
        } t_style_beat;

        string keyword_words[9] = '{"if", "else", "while", "return", "for", "switch",
                                    "case", "break", "continue"};
        string type_words[6]    = '{"int", "char", "void", "float", "double", "bool"};

        t_style_beat pending_q[$];
        int          errors;

        t_lex_mode   mode;
        bit          at_start;
        bit          slash_held;
        bit          long_run;
        logic [7:0]  wchars[WORD_HOLD_DEPTH];
        logic [7:0]  wpriors[WORD_HOLD_DEPTH];
        int          wcount;
        logic [7:0]  step_q[$];

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            mode       = MODE_NORMAL;
            at_start   = 1'b1;
            slash_held = 1'b0;
            long_run   = 1'b0;
            wcount     = 0;
        endfunction

        function bit alpha_byte(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit alnum_byte(logic [7:0] c);
            return alpha_byte(c) || (c >= "0" && c <= "9");
        endfunction

        function bit held_word_is(string s);
            if (s.len() != wcount) begin
                return 1'b0;
            end
            for (int i = 0; i < wcount; i++) begin
                if (s[i] != wchars[i]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function logic [7:0] held_word_style();
            foreach (keyword_words[k]) begin
                if (held_word_is(keyword_words[k])) begin
                    return STYLE_KEYWORD;
                end
            end
            foreach (type_words[k]) begin
                if (held_word_is(type_words[k])) begin
                    return STYLE_TYPE;
                end
            end
            return STYLE_NONE;
        endfunction

        function void flush_held();
            logic [7:0] s;
            if (wcount > 0) begin
                s = held_word_style();
                for (int i = 0; i < wcount; i++) begin
                    step_q.push_back(s != STYLE_NONE ? s : wpriors[i]);
                end
            end
            wcount   = 0;
            long_run = 1'b0;
        endfunction

        // normal mode with nothing held
        function void start_token(logic [7:0] c, logic [7:0] p);
            if (c == CH_SLASH) begin
                slash_held = 1'b1;
            end else if (c == CH_QUOTE) begin
                step_q.push_back(STYLE_STRING);
                mode = MODE_STRING;
            end else if (at_start && c == CH_HASH) begin
                step_q.push_back(STYLE_DIRECTIVE);
                mode = MODE_DIRECTIVE;
            end else if (alpha_byte(c)) begin
                wchars[0]  = c;
                wpriors[0] = p;
                wcount     = 1;
            end else begin
                step_q.push_back(STYLE_DEFAULT);
            end
        endfunction

        function void note_char(logic [7:0] c, logic [7:0] p, logic fin);
            t_style_beat beat;
            step_q.delete();
            if (mode == MODE_COMMENT || mode == MODE_DIRECTIVE) begin
                if (c == CH_NEWLINE) begin
                    mode = MODE_NORMAL;
                    step_q.push_back(STYLE_DEFAULT);
                end else begin
                    step_q.push_back(mode == MODE_COMMENT ? STYLE_COMMENT : STYLE_DIRECTIVE);
                end
            end else if (mode == MODE_STRING) begin
                step_q.push_back(STYLE_STRING);
                if (c == CH_QUOTE) begin
                    mode = MODE_NORMAL;
                end
            end else if (slash_held) begin
                slash_held = 1'b0;
                if (c == CH_SLASH) begin
                    step_q.push_back(STYLE_COMMENT);
                    step_q.push_back(STYLE_COMMENT);
                    mode = MODE_COMMENT;
                end else begin
                    step_q.push_back(STYLE_DEFAULT);
                    start_token(c, p);
                end
            end else if (long_run) begin
                if (alnum_byte(c)) begin
                    step_q.push_back(p);
                end else begin
                    long_run = 1'b0;
                    start_token(c, p);
                end
            end else if (wcount > 0) begin
                if (alnum_byte(c)) begin
                    if (wcount < WORD_HOLD_DEPTH) begin
                        wchars[wcount]  = c;
                        wpriors[wcount] = p;
                        wcount++;
                    end else begin
                        // word outgrew the hold: release it with its stored styles
                        for (int i = 0; i < WORD_HOLD_DEPTH; i++) begin
                            step_q.push_back(wpriors[i]);
                        end
                        step_q.push_back(p);
                        wcount   = 0;
                        long_run = 1'b1;
                    end
                end else begin
                    flush_held();
                    start_token(c, p);
                end
            end else begin
                start_token(c, p);
            end
            at_start = 1'b0;
            if (fin) begin
                flush_held();
                if (slash_held) begin
                    step_q.push_back(STYLE_DEFAULT);
                end
            end
            foreach (step_q[i]) begin
                beat.style = step_q[i];
                beat.last  = fin && (i == step_q.size() - 1);
                pending_q.push_back(beat);
            end
            if (fin) begin
                clear();
            end
        endfunction

        function void check_style(logic [7:0] style, logic last);
            t_style_beat want;
            if (pending_q.size() == 0) begin
                $error("unexpected style beat: char_style %h last_style %b", style, last);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (style !== want.style) begin
                $error("char_style mismatch: expected %h, actual %h", want.style, style);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_style mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // [7:0] text_char, [15:8] prior_style
    logic        i_s_axis_tlast = 1'b0; // end_of_text
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [7:0] char_style
    logic        o_m_axis_tlast;        // last_style

    style_scoreboard sb = new();
    logic [7:0]      text_q[$];
    bit              rx_hold_req = 1'b0;
    int              burst_left = 0;
    int              cycles = 0;

    c_keyword_highlight_lexer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** c_keyword_highlight_lexer_unit: FAILED **");
            $finish;
        end
    end

    // beats are taken at the rising edge; the output side is checked first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_style(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_char(i_s_axis_tdata[7:0], i_s_axis_tdata[15:8], i_s_axis_tlast);
            end
        end
    end

    // receiver: rotating stall patterns, plus one long hold on request
    initial begin
        int rx_cyc;
        int pat;
        rx_cyc = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
            end else begin
                pat = (rx_cyc / 48) % 4;
                case (pat)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= ((rx_cyc % 5) != 0);
                endcase
                rx_cyc++;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_char(input logic [7:0] c, input logic [7:0] p, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p, c};
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_text(input bit edge_priors);
        logic [7:0] p;
        for (int i = 0; i < text_q.size(); i++) begin
            if (edge_priors && (i % 3) != 2) begin
                p = (i % 3 == 0) ? 8'h00 : 8'hFF;
            end else begin
                p = 8'($urandom_range(0, 255));
            end
            send_char(text_q[i], p, i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    // stop offering and wait for every expected style beat
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic add_word(input int len);
        string letters;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
        text_q.push_back(letters[$urandom_range(0, 51)]);
        for (int i = 1; i < len; i++) begin
            text_q.push_back(letters[$urandom_range(0, 61)]);
        end
    endtask

    task automatic add_filler();
        repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic build_random_text();
        int    kind;
        string seps;
        seps = " ;(=+#*\n0129";
        if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CH_HASH);
            add_filler();
            text_q.push_back(CH_NEWLINE);
        end
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1, 2: add_str(sb.keyword_words[$urandom_range(0, 8)]);
                3, 4:    add_str(sb.type_words[$urandom_range(0, 5)]);
                5, 6:    add_word(($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                              : $urandom_range(1, 8));
                7: begin
                    add_str("//");
                    add_filler();
                    if ($urandom_range(0, 3) != 0) begin
                        text_q.push_back(CH_NEWLINE);
                    end
                end
                8: begin
                    text_q.push_back(CH_QUOTE);
                    add_filler();
                    if ($urandom_range(0, 3) != 0) begin
                        text_q.push_back(CH_QUOTE);
                    end
                end
                9:  text_q.push_back(CH_SLASH);
                10: text_q.push_back(8'($urandom_range(0, 255)));
                default: text_q.push_back(seps[$urandom_range(0, seps.len() - 1)]);
            endcase
            // mostly separate words so that the lists get matched
            if (kind <= 6 && $urandom_range(0, 3) != 0) begin
                text_q.push_back(seps[$urandom_range(0, 1)]);
            end
        end
    endtask

    initial begin
        int  random_chars;
        bit  paused;
        random_chars = 0;
        paused       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directive with newline, then a '/' held on the final character
        add_str("#d\n/");
        send_text(1'b1);
        // line comment, a type word and a word held on the final character
        add_str("//c\nint x");
        send_text(1'b1);
        // string, a word that outgrows the hold, non-ascii and zero bytes
        add_str("\"a\"abcdefghij");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text(1'b1);
        drain();

        rx_hold_req = 1'b1;
        while (random_chars < RANDOM_CHARS) begin
            build_random_text();
            random_chars += text_q.size();
            send_text(1'b0);
            if (!paused && random_chars >= RANDOM_CHARS / 2) begin
                paused = 1'b1;
                drain();
            end
        end
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("** c_keyword_highlight_lexer_unit: PASSED **");
        end else begin
            $display("** c_keyword_highlight_lexer_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ckhl_pkg.sv
rtl/ckhl_dp.sv
rtl/ckhl_ctrl.sv
rtl/c_keyword_highlight_lexer_unit.sv
rtl/ckhl_chk.sv
dv/c_keyword_highlight_lexer_unit_tb.sv
